>>> hw/rtl/assert_macros.svh
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define NTB_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// Clocked assertion that also runs during reset.
`define NTB_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

>>> hw/rtl/ntb_pkg.sv
package ntb_pkg;

  // Datapath widths
  localparam int unsigned DW = 64;
  localparam int unsigned QW = 62;
  localparam int unsigned HW = 32;

  // Pipeline depth: prep, four multiplier stages, post
  localparam int unsigned NUM_STAGES  = 6;
  localparam int unsigned LANE_STAGES = 4;

  localparam logic [DW-1:0] LOW32 = 64'h0000_0000_ffff_ffff;

  // Request codes
  localparam logic [1:0] REQ_FWD       = 2'd0;
  localparam logic [1:0] REQ_INV       = 2'd1;
  localparam logic [1:0] REQ_FINAL     = 2'd2;
  localparam logic [1:0] REQ_FINAL_ALT = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_N            = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_N_PRECON     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_N_TW         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_N_TW_PRECON  = 3'd4;

  typedef enum logic [2:0] {
    OP_FWD = 3'b001,
    OP_INV = 3'b010,
    OP_FIN = 3'b100
  } op_t;

  // Operands of one multiply-and-reduce lane
  typedef struct packed {
    logic [DW-1:0] a;
    logic [DW-1:0] w;
    logic [DW-1:0] p;
    logic          exact;
  } lane_in_t;

  // Values that ride alongside the lanes to the final stage
  typedef struct packed {
    op_t           op;
    logic [DW-1:0] xr;
    logic [DW-1:0] s;
  } side_t;

  typedef struct packed {
    logic [QW-1:0] modulus;
    logic [QW-1:0] inv_n;
    logic [DW-1:0] inv_n_precon;
    logic [QW-1:0] inv_n_tw;
    logic [DW-1:0] inv_n_tw_precon;
  } cfg_t;

  function automatic op_t decode_op(input logic [1:0] code);
    op_t op;
    unique case (code)
      REQ_FWD:       op = OP_FWD;
      REQ_INV:       op = OP_INV;
      REQ_FINAL:     op = OP_FIN;
      REQ_FINAL_ALT: op = OP_FIN;
    endcase
    return op;
  endfunction

  function automatic logic [DW-1:0] min64(input logic [DW-1:0] a, input logic [DW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [DW-1:0] zext_q(input logic [QW-1:0] v);
    return {{(DW-QW){1'b0}}, v};
  endfunction

  // 2q, which fits in the 64-bit word since q is below 2^62
  function automatic logic [DW-1:0] twice_q(input logic [QW-1:0] q);
    return {{(DW-QW-1){1'b0}}, q, 1'b0};
  endfunction

endpackage

>>> hw/rtl/ntb_if.sv
// Butterfly request channel
interface ntb_req_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                req_type;
  logic [ntb_pkg::DW-1:0]    x_in;
  logic [ntb_pkg::DW-1:0]    y_in;
  logic [ntb_pkg::QW-1:0]    twiddle;
  logic [ntb_pkg::DW-1:0]    twiddle_precon;

  modport source (output valid, req_type, x_in, y_in, twiddle, twiddle_precon, input ready);
  modport sink   (input valid, req_type, x_in, y_in, twiddle, twiddle_precon, output ready);
endinterface

// Butterfly result channel
interface ntb_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [ntb_pkg::DW-1:0]    x_out;
  logic [ntb_pkg::DW-1:0]    y_out;

  modport source (output valid, x_out, y_out, input ready);
  modport sink   (input valid, x_out, y_out, output ready);
endinterface

>>> hw/rtl/ntb_lane.sv
// One Shoup multiply-and-reduce lane: r = w*a - hi(p*a)*q mod 2^64, four stages.
module ntb_lane (
  input  logic                                clk,
  input  logic [ntb_pkg::LANE_STAGES-1:0]     en,
  input  ntb_pkg::lane_in_t                   op_in,
  input  logic [ntb_pkg::QW-1:0]              q,
  output logic [ntb_pkg::DW-1:0]              r
);

  localparam int unsigned DW = ntb_pkg::DW;
  localparam int unsigned HW = ntb_pkg::HW;
  localparam int unsigned QW = ntb_pkg::QW;

  // Operand halves
  logic [HW-1:0] pl, ph, al, ah, wl, wh;
  assign pl = op_in.p[HW-1:0];
  assign ph = op_in.p[DW-1:HW];
  assign al = op_in.a[HW-1:0];
  assign ah = op_in.a[DW-1:HW];
  assign wl = op_in.w[HW-1:0];
  assign wh = op_in.w[DW-1:HW];

  // Stage 2: partial products of p*a and w*a
  logic [DW-1:0] m_wlh, m_whl;
  assign m_wlh = wl * ah;
  assign m_whl = wh * al;

  logic [DW-1:0] pp_ll, pp_lh, pp_hl, pp_hh, wa_ll;
  logic [HW-1:0] wa_lh, wa_hl;
  logic          exact2;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pp_ll  <= pl * al;
      pp_lh  <= pl * ah;
      pp_hl  <= ph * al;
      pp_hh  <= ph * ah;
      wa_ll  <= wl * al;
      wa_lh  <= m_wlh[HW-1:0];
      wa_hl  <= m_whl[HW-1:0];
      exact2 <= op_in.exact;
    end
  end

  // Stage 3: fold partials into the quotient and the low word of w*a
  logic [DW-1:0] lh_e, mid, quo_c, wa_c;
  logic [HW-1:0] wa_mid;
  always_comb begin
    lh_e   = pp_lh + (exact2 ? {{HW{1'b0}}, pp_ll[DW-1:HW]} : '0);
    mid    = pp_hl + (lh_e & ntb_pkg::LOW32);
    quo_c  = pp_hh + (lh_e >> HW) + (mid >> HW);
    wa_mid = wa_lh + wa_hl;
    wa_c   = wa_ll + {wa_mid, {HW{1'b0}}};
  end

  logic [DW-1:0] quo3, wa3;
  always_ff @(posedge clk) begin
    if (en[1]) begin
      quo3 <= quo_c;
      wa3  <= wa_c;
    end
  end

  // Stage 4: partial products of quo*q, low word only
  logic [HW-1:0] ql, qh, mq_l, mq_h;
  assign ql   = quo3[HW-1:0];
  assign qh   = quo3[DW-1:HW];
  assign mq_l = q[HW-1:0];
  assign mq_h = {{(DW-QW){1'b0}}, q[QW-1:HW]};

  logic [DW-1:0] m_qlh, m_qhl;
  assign m_qlh = ql * mq_h;
  assign m_qhl = qh * mq_l;

  logic [DW-1:0] qq_ll, wa4;
  logic [HW-1:0] qq_lh, qq_hl;
  always_ff @(posedge clk) begin
    if (en[2]) begin
      qq_ll <= ql * mq_l;
      qq_lh <= m_qlh[HW-1:0];
      qq_hl <= m_qhl[HW-1:0];
      wa4   <= wa3;
    end
  end

  // Stage 5: subtract quo*q from w*a
  logic [HW-1:0] qq_mid;
  logic [DW-1:0] qq;
  always_comb begin
    qq_mid = qq_lh + qq_hl;
    qq     = qq_ll + {qq_mid, {HW{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      r <= wa4 - qq;
    end
  end

endmodule

>>> hw/rtl/ntb_prep.sv
// Input stage: lazy pre-reduction, sums and differences, lane operand select.
module ntb_prep (
  input  logic                    clk,
  input  logic                    en,
  input  logic [1:0]              req_type,
  input  logic [ntb_pkg::DW-1:0]  x_in,
  input  logic [ntb_pkg::DW-1:0]  y_in,
  input  logic [ntb_pkg::QW-1:0]  twiddle,
  input  logic [ntb_pkg::DW-1:0]  twiddle_precon,
  input  ntb_pkg::cfg_t           cfg,
  output ntb_pkg::lane_in_t       lane_a,
  output ntb_pkg::lane_in_t       lane_b,
  output ntb_pkg::side_t          side
);

  localparam int unsigned DW = ntb_pkg::DW;

  logic [DW-1:0] q2, xr, ym, t, s_inv, s_sum, s_fin;
  ntb_pkg::op_t  op;
  ntb_pkg::lane_in_t a_c, b_c;

  always_comb begin
    op    = ntb_pkg::decode_op(req_type);
    q2    = ntb_pkg::twice_q(cfg.modulus);
    xr    = ntb_pkg::min64(x_in, x_in - q2);
    ym    = y_in - q2;
    t     = x_in - ym;
    s_inv = x_in + ym;
    // Wrap a negative inverse sum back up by 2q
    if (s_inv[DW-1]) begin
      s_inv = s_inv + q2;
    end
    s_sum = x_in + y_in;
    s_fin = ntb_pkg::min64(s_sum, s_sum - q2);

    // Lane A: twiddle product, or the 1/n scaling in the final mode
    unique case (op)
      ntb_pkg::OP_FWD: begin
        a_c.a     = y_in;
        a_c.w     = ntb_pkg::zext_q(twiddle);
        a_c.p     = twiddle_precon;
        a_c.exact = 1'b0;
      end
      ntb_pkg::OP_INV: begin
        a_c.a     = t;
        a_c.w     = ntb_pkg::zext_q(twiddle);
        a_c.p     = twiddle_precon;
        a_c.exact = 1'b0;
      end
      default: begin
        a_c.a     = s_fin;
        a_c.w     = ntb_pkg::zext_q(cfg.inv_n);
        a_c.p     = cfg.inv_n_precon;
        a_c.exact = 1'b1;
      end
    endcase

    // Lane B: scaled twiddle on the difference, used by the final mode
    b_c.a     = t;
    b_c.w     = ntb_pkg::zext_q(cfg.inv_n_tw);
    b_c.p     = cfg.inv_n_tw_precon;
    b_c.exact = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_a  <= a_c;
      lane_b  <= b_c;
      side.op <= op;
      side.xr <= xr;
      side.s  <= s_inv;
    end
  end

endmodule

>>> hw/rtl/ntb_post.sv
// Output stage: final conditional subtractions and butterfly recombination.
module ntb_post (
  input  logic                    clk,
  input  logic                    en,
  input  logic [ntb_pkg::DW-1:0]  r_a,
  input  logic [ntb_pkg::DW-1:0]  r_b,
  input  ntb_pkg::side_t          side,
  input  logic [ntb_pkg::QW-1:0]  q,
  output logic [ntb_pkg::DW-1:0]  x_out,
  output logic [ntb_pkg::DW-1:0]  y_out
);

  localparam int unsigned DW = ntb_pkg::DW;

  logic [DW-1:0] q1, q2, t, rx, ry;

  always_comb begin
    q1 = ntb_pkg::zext_q(q);
    q2 = ntb_pkg::twice_q(q);
    t  = ntb_pkg::min64(r_a, r_a - q2);
    unique case (side.op)
      ntb_pkg::OP_FWD: begin
        rx = side.xr + t;
        ry = side.xr + (q2 - t);
      end
      ntb_pkg::OP_INV: begin
        rx = side.s;
        ry = t;
      end
      default: begin
        rx = ntb_pkg::min64(r_a, r_a - q1);
        ry = ntb_pkg::min64(r_b, r_b - q1);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_out <= rx;
      y_out <= ry;
    end
  end

endmodule

>>> hw/rtl/ntt_lazy_butterfly_unit.sv
// NTT butterfly with Shoup twiddles and lazy reduction, in a six-stage pipeline that
// accepts one request per cycle while the result side is not stalled. Each request
// is registered through the prep stage, the lane stages and the post stage, and its
// result is held at the output until it is taken. One butterfly per clock is carried by
// two fully pipelined multiply-and-reduce lanes, each of which forms its 32x32
// partial products for w*a and p*a in one stage and those of quotient times modulus
// in another. A stall on the result side holds the pipeline from the last stage
// back, while empty stages upstream keep filling. Forward requests take and give
// values in [0,4q), inverse requests [0,2q); final requests apply the 1/n scaling
// and return values in [0,q). Write the configuration registers only while the
// pipeline is empty.
module ntt_lazy_butterfly_unit (
  input  logic                              clk,
  input  logic                              rst,
  ntb_req_if.sink                           req,
  ntb_rsp_if.source                         rsp,
  input  logic                              cfg_wr_en,
  input  logic [ntb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ntb_pkg::DW-1:0]            cfg_wdata
);

  localparam int unsigned DW = ntb_pkg::DW;
  localparam int unsigned QW = ntb_pkg::QW;
  localparam int unsigned NS = ntb_pkg::NUM_STAGES;
  localparam int unsigned LS = ntb_pkg::LANE_STAGES;

  // Configuration registers
  ntb_pkg::cfg_t cfg;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.modulus         <= QW'(2);
      cfg.inv_n           <= '0;
      cfg.inv_n_precon    <= '0;
      cfg.inv_n_tw        <= '0;
      cfg.inv_n_tw_precon <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        ntb_pkg::CFG_MODULUS:         cfg.modulus         <= cfg_wdata[QW-1:0];
        ntb_pkg::CFG_INV_N:           cfg.inv_n           <= cfg_wdata[QW-1:0];
        ntb_pkg::CFG_INV_N_PRECON:    cfg.inv_n_precon    <= cfg_wdata;
        ntb_pkg::CFG_INV_N_TW:        cfg.inv_n_tw        <= cfg_wdata[QW-1:0];
        ntb_pkg::CFG_INV_N_TW_PRECON: cfg.inv_n_tw_precon <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stage valid bits and advance chain, last stage first
  logic [NS:1]   vld;
  logic [NS+1:1] adv;
  always_comb begin
    adv[NS+1] = rsp.ready;
    for (int k = NS; k >= 1; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) begin
        vld[1] <= req.valid;
      end
      for (int k = 2; k <= NS; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign req.ready = adv[1];
  assign rsp.valid = vld[NS];

  // Stage 1
  ntb_pkg::lane_in_t lane_a, lane_b;
  ntb_pkg::side_t    side1;

  ntb_prep u_prep (
    .clk            (clk),
    .en             (adv[1]),
    .req_type       (req.req_type),
    .x_in           (req.x_in),
    .y_in           (req.y_in),
    .twiddle        (req.twiddle),
    .twiddle_precon (req.twiddle_precon),
    .cfg            (cfg),
    .lane_a         (lane_a),
    .lane_b         (lane_b),
    .side           (side1)
  );

  // Stages 2 to 5
  logic [LS-1:0] lane_en;
  assign lane_en = adv[LS+1:2];

  logic [DW-1:0] r_a, r_b;

  ntb_lane u_lane_a (
    .clk   (clk),
    .en    (lane_en),
    .op_in (lane_a),
    .q     (cfg.modulus),
    .r     (r_a)
  );

  ntb_lane u_lane_b (
    .clk   (clk),
    .en    (lane_en),
    .op_in (lane_b),
    .q     (cfg.modulus),
    .r     (r_b)
  );

  // Carry the side values along the lane stages
  ntb_pkg::side_t side_d [LS];
  always_ff @(posedge clk) begin
    if (lane_en[0]) begin
      side_d[0] <= side1;
    end
    for (int k = 1; k < LS; k++) begin
      if (lane_en[k]) begin
        side_d[k] <= side_d[k-1];
      end
    end
  end

  // Stage 6
  ntb_post u_post (
    .clk   (clk),
    .en    (adv[NS]),
    .r_a   (r_a),
    .r_b   (r_b),
    .side  (side_d[LS-1]),
    .q     (cfg.modulus),
    .x_out (rsp.x_out),
    .y_out (rsp.y_out)
  );

endmodule

>>> hw/rtl/ntb_checker.sv
`include "assert_macros.svh"

// Port-level checks of the butterfly pipeline.
module ntb_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   req_valid,
  input logic                   req_ready,
  input logic                   rsp_valid,
  input logic                   rsp_ready,
  input logic [ntb_pkg::DW-1:0] x_out,
  input logic [ntb_pkg::DW-1:0] y_out
);

  // Hold a stalled result
  `NTB_ASSERT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid && $stable(x_out) && $stable(y_out), "stalled result changed")

  // Drop all results on reset
  `NTB_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !rsp_valid, "result valid after reset")

  // An empty output stage never blocks requests
  `NTB_ASSERT(a_empty_ready, clk, rst, !rsp_valid |-> req_ready, "request blocked with empty output")

  // A taken result lets the whole pipeline advance
  `NTB_ASSERT(a_take_ready, clk, rst, rsp_ready |-> req_ready, "request blocked while result side is ready")

  // Accepting a request while the result is taken keeps the pipeline moving
  `NTB_ASSERT(a_flow, clk, rst, req_valid && req_ready && rsp_ready |=> req_ready || !rsp_ready, "pipeline stalled without back-pressure")

endmodule

bind ntt_lazy_butterfly_unit ntb_checker u_ntb_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .x_out     (rsp.x_out),
  .y_out     (rsp.y_out)
);

>>> test/ntt_lazy_butterfly_unit_tb.sv
module ntt_lazy_butterfly_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] MASK62      = 64'h3fff_ffff_ffff_ffff;
  localparam logic [63:0] ALL_ONES    = 64'hffff_ffff_ffff_ffff;
  localparam int          STALL_LIMIT = 4000;
  localparam int          TAIL_CYCLES = ntb_pkg::NUM_STAGES + 10;

  typedef struct {
    logic [1:0]  kind;
    logic [63:0] x;
    logic [63:0] y;
    logic [61:0] w;
    logic [63:0] wp;
  } bfly_req_t;

  typedef struct {
    logic [63:0] x;
    logic [63:0] y;
  } bfly_rsp_t;

  typedef struct {
    logic [63:0] modulus;
    logic [63:0] inv_n;
    logic [63:0] inv_n_pre;
    logic [63:0] inv_tw;
    logic [63:0] inv_tw_pre;
  } ntt_regs_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [ntb_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [63:0] cfg_wdata;

  ntb_req_if req_bus ();
  ntb_rsp_if rsp_bus ();

  ntt_lazy_butterfly_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_bus),
    .rsp       (rsp_bus),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  ntt_regs_t  regs;
  bfly_rsp_t  expected_outputs[$];
  int         error_count;
  int         burst_left;

  // ---------------------------------------------------------------- arithmetic
  function automatic logic [63:0] lower_of(input logic [63:0] a, input logic [63:0] b);
    return (a < b) ? a : b;
  endfunction

  // High word of a*b; the approximate form drops the low-by-low partial
  function automatic logic [63:0] mul_high(input logic [63:0] a, input logic [63:0] b,
                                           input bit exact);
    logic [63:0] al, ah, bl, bh, ll, lh, hl, hh, mid;
    al = a & ntb_pkg::LOW32;
    ah = a >> 32;
    bl = b & ntb_pkg::LOW32;
    bh = b >> 32;
    ll = al * bl;
    lh = al * bh;
    if (exact) begin
      lh = lh + (ll >> 32);
    end
    hl = ah * bl;
    hh = ah * bh;
    mid = hl + (lh & ntb_pkg::LOW32);
    return hh + (lh >> 32) + (mid >> 32);
  endfunction

  // floor(w * 2^64 / q)
  function automatic logic [63:0] shoup_of(input logic [63:0] w, input logic [63:0] q);
    logic [127:0] num, quo;
    num = {w, 64'd0};
    quo = num / {64'd0, q};
    return quo[63:0];
  endfunction

  function automatic bfly_rsp_t butterfly_predict(input ntt_regs_t r, input bfly_req_t a);
    logic [63:0] q, q2, x, y, w, xr, t, s, ym, quo, rx, ry;
    bfly_rsp_t res;
    q  = r.modulus;
    q2 = q + q;
    x  = a.x;
    y  = a.y;
    w  = {2'b00, a.w};
    case (a.kind)
      ntb_pkg::REQ_FWD: begin
        xr  = lower_of(x, x - q2);
        quo = mul_high(a.wp, y, 1'b0);
        t   = w * y - quo * q;
        t   = lower_of(t, t - q2);
        ry  = xr + (q2 - t);
        rx  = xr + t;
      end
      ntb_pkg::REQ_INV: begin
        ym = y - q2;
        t  = x - ym;
        s  = x + ym;
        if (s[63]) begin
          s = s + q2;
        end
        rx  = s;
        quo = mul_high(a.wp, t, 1'b0);
        ry  = w * t - quo * q;
        ry  = lower_of(ry, ry - q2);
      end
      default: begin
        // final stage: both codes with the high bit set
        ym  = y - q2;
        t   = x - ym;
        s   = x + y;
        s   = lower_of(s, s - q2);
        quo = mul_high(r.inv_n_pre, s, 1'b1);
        rx  = r.inv_n * s - quo * q;
        quo = mul_high(r.inv_tw_pre, t, 1'b1);
        ry  = r.inv_tw * t - quo * q;
        rx  = lower_of(rx, rx - q);
        ry  = lower_of(ry, ry - q);
      end
    endcase
    res.x = rx;
    res.y = ry;
    return res;
  endfunction

  // ---------------------------------------------------------------- random values
  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Value in [0,bound), with the two ends picked often
  function automatic logic [63:0] rand_below(input logic [63:0] bound);
    case ($urandom_range(15))
      0: return 64'd0;
      1: return bound - 64'd1;
      default: return rand64() % bound;
    endcase
  endfunction

  function automatic logic [63:0] rand_modulus();
    logic [63:0] q;
    q = rand64() >> (64 - $urandom_range(2, 62));
    return (q < 64'd2) ? 64'd2 : q;
  endfunction

  function automatic bfly_req_t make_req(input logic [1:0] kind, input logic [63:0] x,
                                         input logic [63:0] y, input logic [63:0] w,
                                         input logic [63:0] wp);
    bfly_req_t r;
    r.kind = kind;
    r.x    = x;
    r.y    = y;
    r.w    = w[61:0];
    r.wp   = wp;
    return r;
  endfunction

  // Mostly well-formed butterflies for the current modulus, some raw noise
  function automatic bfly_req_t random_request();
    logic [1:0]  kind;
    logic [63:0] q, bound, w;
    q    = regs.modulus;
    kind = 2'($urandom_range(3));
    if ($urandom_range(9) == 0) begin
      return make_req(kind, rand64(), rand64(), rand64(), rand64());
    end
    bound = (kind == ntb_pkg::REQ_FWD) ? (q << 2) : (q << 1);
    w     = rand_below(q);
    return make_req(kind, rand_below(bound), rand_below(bound), w, shoup_of(w, q));
  endfunction

  // ---------------------------------------------------------------- request side
  task automatic send_req(input bfly_req_t r);
    @(negedge clk);
    req_bus.valid          = 1'b1;
    req_bus.req_type       = r.kind;
    req_bus.x_in           = r.x;
    req_bus.y_in           = r.y;
    req_bus.twiddle        = r.w;
    req_bus.twiddle_precon = r.wp;
    @(posedge clk);
    while (!req_bus.ready) begin
      @(posedge clk);
    end
    expected_outputs.push_back(butterfly_predict(regs, r));
    // burst pacing: gap only when the current burst runs out
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      pause_req($urandom_range(1, 8));
      burst_left = $urandom_range(0, 40);
    end
  endtask

  task automatic pause_req(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      req_bus.valid = 1'b0;
    end
  endtask

  // Hold off until every issued request has come back and the pipe is empty
  task automatic wait_idle();
    pause_req(1);
    while (expected_outputs.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- registers
  task automatic write_reg(input logic [ntb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [63:0] value);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(posedge clk);
    case (idx)
      ntb_pkg::CFG_MODULUS:         regs.modulus    = value & MASK62;
      ntb_pkg::CFG_INV_N:           regs.inv_n      = value & MASK62;
      ntb_pkg::CFG_INV_N_PRECON:    regs.inv_n_pre  = value;
      ntb_pkg::CFG_INV_N_TW:        regs.inv_tw     = value & MASK62;
      ntb_pkg::CFG_INV_N_TW_PRECON: regs.inv_tw_pre = value;
      default: ;
    endcase
  endtask

  task automatic load_regs(input logic [63:0] q, input logic [63:0] inv_n,
                           input logic [63:0] inv_n_pre, input logic [63:0] inv_tw,
                           input logic [63:0] inv_tw_pre);
    wait_idle();
    write_reg(ntb_pkg::CFG_MODULUS, q);
    write_reg(ntb_pkg::CFG_INV_N, inv_n);
    write_reg(ntb_pkg::CFG_INV_N_PRECON, inv_n_pre);
    write_reg(ntb_pkg::CFG_INV_N_TW, inv_tw);
    write_reg(ntb_pkg::CFG_INV_N_TW_PRECON, inv_tw_pre);
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Consistent constants for q; junk in the unused top bits must be dropped
  task automatic load_modulus(input logic [63:0] q);
    logic [63:0] inv_n, inv_tw;
    q      = q & MASK62;
    inv_n  = rand_below(q);
    inv_tw = rand_below(q);
    load_regs({2'($urandom), q[61:0]}, {2'($urandom), inv_n[61:0]}, shoup_of(inv_n, q),
              {2'($urandom), inv_tw[61:0]}, shoup_of(inv_tw, q));
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_reset_defaults();
    send_req(make_req(ntb_pkg::REQ_FWD, 64'd7, 64'd5, 64'd1, shoup_of(64'd1, 64'd2)));
    send_req(make_req(ntb_pkg::REQ_INV, 64'd3, 64'd2, 64'd1, shoup_of(64'd1, 64'd2)));
    send_req(make_req(ntb_pkg::REQ_FINAL, 64'd3, 64'd3, 64'd0, 64'd0));
  endtask

  task automatic test_operand_extremes();
    logic [63:0] q, q2, q4, wmax, pmax, p1;
    load_modulus(MASK62);
    q    = regs.modulus;
    q2   = q << 1;
    q4   = q << 2;
    wmax = q - 64'd1;
    pmax = shoup_of(wmax, q);
    p1   = shoup_of(64'd1, q);
    send_req(make_req(ntb_pkg::REQ_FWD, 64'd0, 64'd0, 64'd0, 64'd0));
    send_req(make_req(ntb_pkg::REQ_FWD, q4 - 64'd1, q4 - 64'd1, wmax, pmax));
    send_req(make_req(ntb_pkg::REQ_FWD, q4 - 64'd1, 64'd0, 64'd1, p1));
    send_req(make_req(ntb_pkg::REQ_INV, 64'd0, 64'd0, 64'd0, 64'd0));
    send_req(make_req(ntb_pkg::REQ_INV, q2 - 64'd1, q2 - 64'd1, wmax, pmax));
    // sum below 2q wraps negative and is corrected
    send_req(make_req(ntb_pkg::REQ_INV, 64'd0, q2 - 64'd1, 64'd1, p1));
    send_req(make_req(ntb_pkg::REQ_INV, q2 - 64'd1, 64'd0, wmax, pmax));
    send_req(make_req(ntb_pkg::REQ_FINAL, q2 - 64'd1, q2 - 64'd1, wmax, pmax));
    send_req(make_req(ntb_pkg::REQ_FINAL, 64'd0, q2 - 64'd1, 64'd0, 64'd0));
    send_req(make_req(ntb_pkg::REQ_FINAL, q2 - 64'd1, 64'd0, 64'd1, p1));
    // unused code behaves as the final stage
    send_req(make_req(ntb_pkg::REQ_FINAL_ALT, q - 64'd1, 64'd1, wmax, pmax));
    // operands far outside the lazy range
    send_req(make_req(ntb_pkg::REQ_FWD, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES));
    send_req(make_req(ntb_pkg::REQ_INV, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES));
    send_req(make_req(ntb_pkg::REQ_FINAL, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES));
  endtask

  task automatic test_random_stream(input int count);
    repeat (count) begin
      send_req(random_request());
    end
  endtask

  task automatic test_small_moduli();
    load_modulus(64'd2);
    test_random_stream(150);
    load_modulus(64'd3);
    test_random_stream(100);
  endtask

  // Constants that do not belong to the modulus, at both extremes
  task automatic test_raw_registers();
    load_regs(rand_modulus(), ALL_ONES, ALL_ONES, 64'd0, 64'd0);
    test_random_stream(75);
    load_regs(rand_modulus(), 64'd0, 64'd0, ALL_ONES, ALL_ONES);
    test_random_stream(75);
  endtask

  task automatic test_random_moduli();
    repeat (4) begin
      load_modulus(rand_modulus());
      test_random_stream(310);
    end
  endtask

  // ---------------------------------------------------------------- processes
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Result-side stalls: stretches of full rate, random, patterned and long holds
  initial begin : result_backpressure
    int mode, span, hold;
    logic [15:0] pat;
    rsp_bus.ready = 1'b0;
    forever begin
      mode = $urandom_range(3);
      span = $urandom_range(20, 200);
      hold = $urandom_range(1, 20);
      pat  = 16'($urandom);
      for (int c = 0; c < span; c++) begin
        @(negedge clk);
        case (mode)
          0: rsp_bus.ready = 1'b1;
          1: rsp_bus.ready = ($urandom_range(3) != 0);
          2: rsp_bus.ready = pat[c % 16];
          default: rsp_bus.ready = ((c % 32) >= hold);
        endcase
      end
    end
  end

  // Compare each result against the oldest prediction
  initial begin : result_check
    bfly_rsp_t want;
    forever begin
      @(posedge clk);
      if (!rst && rsp_bus.valid && rsp_bus.ready) begin
        if (expected_outputs.size() == 0) begin
          error_count++;
          if (error_count <= 10) begin
            $display("unexpected result: x_out %h y_out %h", rsp_bus.x_out, rsp_bus.y_out);
          end
        end else begin
          want = expected_outputs.pop_front();
          if (rsp_bus.x_out !== want.x || rsp_bus.y_out !== want.y) begin
            error_count++;
            if (error_count <= 10) begin
              $display("mismatch: x_out exp %h got %h, y_out exp %h got %h",
                       want.x, rsp_bus.x_out, want.y, rsp_bus.y_out);
            end
          end
        end
      end
    end
  end

  // End the run if neither side moves for too long
  initial begin : stall_watch
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[ntt_lazy_butterfly_unit] ERROR");
    $finish;
  end

  initial begin
    error_count            = 0;
    burst_left             = 0;
    rst                    = 1'b1;
    cfg_wr_en              = 1'b0;
    cfg_index              = ntb_pkg::CFG_MODULUS;
    cfg_wdata              = 64'd0;
    req_bus.valid          = 1'b0;
    req_bus.req_type       = ntb_pkg::REQ_FWD;
    req_bus.x_in           = 64'd0;
    req_bus.y_in           = 64'd0;
    req_bus.twiddle        = 62'd0;
    req_bus.twiddle_precon = 64'd0;
    regs.modulus           = 64'd2;
    regs.inv_n             = 64'd0;
    regs.inv_n_pre         = 64'd0;
    regs.inv_tw            = 64'd0;
    regs.inv_tw_pre        = 64'd0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_operand_extremes();
    test_random_stream(300);
    test_small_moduli();
    test_raw_registers();
    test_random_moduli();
    wait_idle();

    if (error_count == 0) begin
      $display("[ntt_lazy_butterfly_unit] OK");
    end else begin
      $display("[ntt_lazy_butterfly_unit] ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/ntb_pkg.sv
hw/rtl/ntb_if.sv
hw/rtl/ntb_lane.sv
hw/rtl/ntb_prep.sv
hw/rtl/ntb_post.sv
hw/rtl/ntt_lazy_butterfly_unit.sv
hw/rtl/ntb_checker.sv
test/ntt_lazy_butterfly_unit_tb.sv
